// ===== rtl/fsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_pkg
// shared types and constants for the four-servo sequenced pulse generator
// ----------------------------------------------------------------------------
package fsp_pkg;

	localparam int NUM_SERVOS = 4;

	localparam logic [7:0] REST_POSITION    = 8'd150;
	localparam logic [7:0] HOLD_FRAMES      = 8'd50;
	localparam logic [7:0] HEARTBEAT_FRAMES = 8'd50;

	localparam logic [8:0] FINE_MAX   = 9'd511;
	localparam logic [2:0] DIM_MASK   = 3'd7;
	localparam logic [2:0] PHASE_IDLE = 3'd4;
	localparam logic [2:0] PHASE_LAST = 3'd3;

	typedef enum logic {
		KIND_FINE = 1'b0,
		KIND_SLOT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		MODE_INACTIVE = 2'd0,
		MODE_MOVING   = 2'd1,
		MODE_DWELL    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CFG_END_LOW  = 3'd0,
		CFG_END_HIGH = 3'd1,
		CFG_DWELL    = 3'd2,
		CFG_HOLD_EN  = 3'd3,
		CFG_SINGLE   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] end_low;
		logic [31:0] end_high;
		logic [9:0]  dwell_frames;
		logic        hold_enable;
		logic        single_input;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic  in_zero;
		logic  in_one;
	} item_t;

	typedef struct packed {
		logic [3:0] servo_pins;
		logic       status_led;
		mode_t      run_mode;
		logic       frame_done;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/fsp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_cfg
// configuration register file, one write per cycle
// ----------------------------------------------------------------------------
module fsp_cfg
	import fsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [31:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_low      <= {4{REST_POSITION}};
			cfg_q.end_high     <= {4{REST_POSITION}};
			cfg_q.dwell_frames <= '0;
			cfg_q.hold_enable  <= 1'b0;
			cfg_q.single_input <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_END_LOW:  cfg_q.end_low      <= wr_data;
				CFG_END_HIGH: cfg_q.end_high     <= wr_data;
				CFG_DWELL:    cfg_q.dwell_frames <= wr_data[9:0];
				CFG_HOLD_EN:  cfg_q.hold_enable  <= wr_data[0];
				CFG_SINGLE:   cfg_q.single_input <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/fsp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_core
// servo, slot, dwell and heartbeat state with its single-pass update per word
// ----------------------------------------------------------------------------
module fsp_core
	import fsp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	logic [7:0] width_q [NUM_SERVOS];
	logic [7:0] width_d [NUM_SERVOS];
	logic       tend_q  [NUM_SERVOS];
	logic       tend_d  [NUM_SERVOS];
	logic       hlev_q  [NUM_SERVOS];
	logic       hlev_d  [NUM_SERVOS];
	logic [7:0] htmr_q  [NUM_SERVOS];
	logic [7:0] htmr_d  [NUM_SERVOS];
	logic [7:0] tgt     [NUM_SERVOS];
	logic [1:0] ord     [NUM_SERVOS];

	logic [2:0] phase_q, phase_d;
	logic [8:0] fine_q, fine_d, fine_inc;
	logic [3:0] pins_q, pins_d;
	mode_t      mode_q, mode_d;
	logic [9:0] dwell_q, dwell_d, dwell_dec;
	logic [7:0] hbeat_q, hbeat_d;
	logic       led_q, led_d;
	logic [1:0] order_q, order_d;

	logic       found;
	logic [1:0] sel;
	logic [7:0] moved;
	logic       other;
	logic       done;

	// targets and search order
	always_comb begin
		for (int s = 0; s < NUM_SERVOS; s++) begin
			tgt[s] = tend_q[s] ? cfg.end_high[8*s +: 8] : cfg.end_low[8*s +: 8];
		end
		if (order_q == 2'b11) begin
			ord[0] = 2'd3;
			ord[1] = 2'd2;
			ord[2] = 2'd1;
			ord[3] = 2'd0;
		end else begin
			ord[0] = order_q[0] ? 2'd1 : 2'd0;
			ord[1] = order_q[0] ? 2'd0 : 2'd1;
			ord[2] = order_q[1] ? 2'd3 : 2'd2;
			ord[3] = order_q[1] ? 2'd2 : 2'd3;
		end
		found = 1'b0;
		sel   = 2'd0;
		for (int i = 0; i < NUM_SERVOS; i++) begin
			if (!found && (width_q[ord[i]] != tgt[ord[i]])) begin
				found = 1'b1;
				sel   = ord[i];
			end
		end
	end

	assign fine_inc  = (fine_q == FINE_MAX) ? fine_q : fine_q + 9'd1;
	assign dwell_dec = dwell_q - 10'd1;
	assign moved     = (width_q[sel] > tgt[sel]) ? width_q[sel] - 8'd1 : width_q[sel] + 8'd1;
	assign other     = cfg.single_input ? item.in_zero : item.in_one;

	always_comb begin
		width_d = width_q;
		tend_d  = tend_q;
		hlev_d  = hlev_q;
		htmr_d  = htmr_q;
		phase_d = phase_q;
		fine_d  = fine_q;
		pins_d  = pins_q;
		mode_d  = mode_q;
		dwell_d = dwell_q;
		hbeat_d = hbeat_q;
		led_d   = led_q;
		order_d = order_q;
		done    = 1'b0;
		if (en) begin
			if (item.kind == KIND_FINE) begin
				fine_d = fine_inc;
				if (phase_q < PHASE_IDLE) begin
					if (fine_inc >= {1'b0, width_q[phase_q[1:0]]}) begin
						pins_d[phase_q[1:0]] = hlev_q[phase_q[1:0]];
					end
				end
			end else begin
				fine_d = '0;
				if (phase_q == PHASE_IDLE) begin
					phase_d   = 3'd0;
					pins_d[0] = 1'b1;
				end else if (phase_q < PHASE_LAST) begin
					phase_d            = phase_q + 3'd1;
					pins_d[phase_d[1:0]] = 1'b1;
				end else begin
					done    = 1'b1;
					phase_d = PHASE_IDLE;
					// at most one servo steps per frame
					if (mode_q != MODE_DWELL && found) begin
						hlev_d[sel]  = 1'b0;
						width_d[sel] = moved;
						if (moved != tgt[sel]) begin
							mode_d = MODE_MOVING;
						end else begin
							htmr_d[sel] = cfg.hold_enable ? HOLD_FRAMES : 8'd0;
							mode_d      = MODE_DWELL;
						end
					end
					case (mode_d)
						MODE_MOVING: begin
							led_d   = 1'b1;
							dwell_d = cfg.dwell_frames;
						end
						MODE_DWELL: begin
							if (dwell_q != 10'd0) begin
								dwell_d = dwell_dec;
								led_d   = (dwell_dec[2:0] & DIM_MASK) == 3'd0;
							end else begin
								led_d  = 1'b0;
								mode_d = MODE_INACTIVE;
							end
						end
						MODE_INACTIVE: begin
							if (hbeat_q != 8'd0) begin
								hbeat_d = hbeat_q - 8'd1;
								led_d   = 1'b0;
							end else begin
								hbeat_d = HEARTBEAT_FRAMES;
								led_d   = 1'b1;
							end
							tend_d[0] = item.in_zero;
							tend_d[1] = item.in_zero;
							tend_d[2] = other;
							tend_d[3] = other;
							order_d   = {other, item.in_zero};
						end
						default: ;
					endcase
					for (int s = 0; s < NUM_SERVOS; s++) begin
						if (htmr_d[s] != 8'd0) begin
							htmr_d[s] = htmr_d[s] - 8'd1;
							if (htmr_d[s] == 8'd0) begin
								hlev_d[s] = cfg.hold_enable;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SERVOS; s++) begin
				width_q[s] <= REST_POSITION;
				tend_q[s]  <= 1'b0;
				hlev_q[s]  <= 1'b0;
				htmr_q[s]  <= 8'd0;
			end
			phase_q <= PHASE_IDLE;
			fine_q  <= '0;
			pins_q  <= '0;
			mode_q  <= MODE_INACTIVE;
			dwell_q <= '0;
			hbeat_q <= '0;
			led_q   <= 1'b0;
			order_q <= '0;
		end else begin
			width_q <= width_d;
			tend_q  <= tend_d;
			hlev_q  <= hlev_d;
			htmr_q  <= htmr_d;
			phase_q <= phase_d;
			fine_q  <= fine_d;
			pins_q  <= pins_d;
			mode_q  <= mode_d;
			dwell_q <= dwell_d;
			hbeat_q <= hbeat_d;
			led_q   <= led_d;
			order_q <= order_d;
		end
	end

	assign res.servo_pins = pins_d;
	assign res.status_led = led_d;
	assign res.run_mode   = mode_d;
	assign res.frame_done = done;

	a_fine_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.kind == KIND_FINE |-> !res.frame_done)
		else $error("frame step on a fine tick");

	a_frame_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.frame_done |=> phase_q == PHASE_IDLE)
		else $error("slot phase not idle after frame end");

	a_slot_clears_fine: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.kind == KIND_SLOT |=> fine_q == 9'd0)
		else $error("fine count not cleared by slot tick");

endmodule
`default_nettype wire

// ===== rtl/four_servo_sequenced_pwm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_servo_sequenced_pwm
// time-multiplexed pulse generator for four sequenced servos
// ----------------------------------------------------------------------------
// Each input word is one tick: tuser selects a fine tick (0) or a slot tick (1),
// tdata carries the two control input levels. Every word yields exactly one
// output word with the four pin levels, the LED level and the run mode in
// tdata, and tuser set when that tick closed a frame and ran the frame step.
// The cfg channel writes the five setup registers by index; it is always
// ready and is meant to be used while no word is in flight.
// A word is captured in the input register, then its state update and result
// are formed in one pass and land in the output register.
// Throughput: one word per cycle while m_tready holds; only output stalls limit it.
// When the receiver stalls, the held result waits and one more word may sit
// in the input register; s_tready drops only when both are full.
// Reset clears all servo widths to the rest position, the slot phase to the
// idle slot and the mode to inactive; no clearing pass is needed.
// ----------------------------------------------------------------------------
module four_servo_sequenced_pwm
	import fsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // in_zero, in_one, zero fill
	input  wire logic        s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // servo_pins[3:0], status_led, run_mode[1:0], zero
	output logic             m_tuser,   // frame_done
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;
	result_t res_s2;
	logic    valid_s2;

	assign cfg_ready = 1'b1;

	fsp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind    <= kind_t'(s_tuser);
			item_s1.in_zero <= s_tdata[0];
			item_s1.in_one  <= s_tdata[1];
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	fsp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.run_mode, res_s2.status_led, res_s2.servo_pins};
	assign m_tuser  = res_s2.frame_done;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input taken while both stages are full");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result lost after advance");

	a_drain_empties_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !advance |=> !m_tvalid)
		else $error("result repeated after it was taken");

endmodule
`default_nettype wire
